// ===== design/cst_pkg.sv =====
// Package for the call site count table: sizes, command codes, beat types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cst_pkg;
    localparam int ENTRIES = 64;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    localparam logic [1:0] CMD_RECORD = 2'd0;
    localparam logic [1:0] CMD_REPORT = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] site_key;
        logic        marked;
    } cmd_beat_t;

    typedef struct packed {
        logic [63:0] site_key_res;
        logic [15:0] total_count;
        logic [15:0] mark_count;
        logic        empty_res;
        logic [15:0] dropped_count;
        logic        last;
    } res_beat_t;
endpackage
`default_nettype wire

// ===== design/cst_cmd_if.sv =====
// Command channel interface (valid/ready). No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface cst_cmd_if;
    logic valid;
    logic ready;
    logic [1:0] command;
    logic [63:0] site_key;
    logic marked;
    modport source (output valid, command, site_key, marked, input ready);
    modport sink (input valid, command, site_key, marked, output ready);
endinterface
`default_nettype wire

// ===== design/cst_res_if.sv =====
// Result channel interface (valid/ready). No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface cst_res_if;
    logic valid;
    logic ready;
    logic [63:0] site_key_res;
    logic [15:0] total_count;
    logic [15:0] mark_count;
    logic empty_res;
    logic [15:0] dropped_count;
    logic last;
    modport source (output valid, site_key_res, total_count, mark_count, empty_res,
                    dropped_count, last, input ready);
    modport sink (input valid, site_key_res, total_count, mark_count, empty_res,
                  dropped_count, last, output ready);
endinterface
`default_nettype wire

// ===== design/call_site_count_table.sv =====
// Call site count table top level: key/count memories, scan sequencer, sorted readout.
// Depends on cst_pkg, cst_cmd_if, cst_res_if.
// Record: linear scan, one memory read a cycle, then a write-back.
// Report: selection sort over the count memory, one full scan plus
//   pick and emit per beat; the single read port makes a full scan per beat necessary.
// Clear empties the table. One command is in progress at a time; results hold until taken.
// Reset (async, active low) empties the table; the memories keep their contents.
`timescale 1ns / 1ps
`default_nettype none
module call_site_count_table (
    input  wire logic clk,
    input  wire logic rst_n,
    cst_cmd_if.sink   cmd,
    cst_res_if.source res
);
    import cst_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RSCAN = 3'd1;
    localparam logic [2:0] S_RWB   = 3'd2;
    localparam logic [2:0] S_PSCAN = 3'd3;
    localparam logic [2:0] S_PEMIT = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [63:0] key_mem [ENTRIES];
    logic [15:0] tot_mem [ENTRIES];
    logic [15:0] mrk_mem [ENTRIES];

    logic [2:0] state_reg, state_next;
    logic [CNT_W-1:0] count_reg;
    logic any_reg;
    logic [15:0] drop_reg;
    logic [63:0] key_reg;
    logic mark_reg;

    // scan: address issued, and the one whose data is present
    logic [CNT_W-1:0] addr_reg;
    logic rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [63:0] key_rd_reg;
    logic [15:0] tot_rd_reg, mrk_rd_reg;

    logic hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [15:0] hit_tot_reg, hit_mrk_reg;

    // selection sort: emitted set, emitted count, current best (value, index, entry)
    logic [ENTRIES-1:0] done_reg;
    logic [CNT_W-1:0] emitted_reg;
    logic best_vld_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [15:0] best_val_reg;
    logic [63:0] best_key_reg;
    logic [15:0] best_tot_reg, best_mrk_reg;

    res_beat_t out_reg;
    logic out_vld_reg;

    logic accept;
    assign cmd.ready = (state_reg == S_IDLE);
    assign accept = cmd.valid && cmd.ready;

    wire logic [15:0] sk_val = any_reg ? mrk_rd_reg : tot_rd_reg;
    // descending, stable: strictly larger wins, earlier index wins ties
    wire logic better = !best_vld_reg || (sk_val > best_val_reg);

    logic wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [63:0] wr_key;
    logic [15:0] wr_tot, wr_mrk;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_idx] <= wr_key;
            tot_mem[wr_idx] <= wr_tot;
            mrk_mem[wr_idx] <= wr_mrk;
        end
        key_rd_reg <= key_mem[addr_reg[IDX_W-1:0]];
        tot_rd_reg <= tot_mem[addr_reg[IDX_W-1:0]];
        mrk_rd_reg <= mrk_mem[addr_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        wr_en = 1'b0;
        wr_idx = hit_idx_reg;
        wr_key = key_reg;
        wr_tot = '0;
        wr_mrk = '0;
        if (state_reg == S_RWB)
        begin
            if (hit_reg)
            begin
                wr_en = 1'b1;
                wr_tot = (hit_tot_reg == CNT_MAX) ? CNT_MAX : hit_tot_reg + 16'd1;
                wr_mrk = (mark_reg && hit_mrk_reg != CNT_MAX) ? hit_mrk_reg + 16'd1
                                                              : hit_mrk_reg;
            end
            else if (count_reg < CNT_W'(ENTRIES))
            begin
                wr_en = 1'b1;
                wr_idx = count_reg[IDX_W-1:0];
                wr_tot = 16'd1;
                wr_mrk = {15'd0, mark_reg};
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.command)
                        CMD_RECORD: state_next = S_RSCAN;
                        CMD_REPORT: state_next = (count_reg == '0) ? S_OUT : S_PSCAN;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_RSCAN:
                if ((addr_reg >= count_reg && !rd_vld_reg)
                    || (rd_vld_reg && key_rd_reg == key_reg))
                    state_next = S_RWB;
            S_RWB:   state_next = S_IDLE;
            S_PSCAN: if (addr_reg >= count_reg && !rd_vld_reg) state_next = S_PEMIT;
            S_PEMIT: if (!out_vld_reg) state_next = S_OUT;
            S_OUT:
            begin
                if (!out_vld_reg)
                    state_next = (emitted_reg >= count_reg) ? S_IDLE : S_PSCAN;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            any_reg     <= 1'b0;
            drop_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            best_vld_reg <= 1'b0;
            done_reg    <= '0;
            emitted_reg <= '0;
            addr_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_vld_reg && res.ready)
                out_vld_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    addr_reg <= '0;
                    rd_vld_reg <= 1'b0;
                    hit_reg <= 1'b0;
                    best_vld_reg <= 1'b0;
                    done_reg <= '0;
                    emitted_reg <= '0;
                    key_reg <= cmd.site_key;
                    mark_reg <= cmd.marked;
                    if (accept && cmd.command == CMD_CLEAR)
                    begin
                        count_reg <= '0;
                        any_reg <= 1'b0;
                        drop_reg <= '0;
                    end
                    if (accept && cmd.command == CMD_REPORT && count_reg == '0)
                    begin
                        // empty report: build the lone beat now, shown in S_OUT
                        best_key_reg <= '0;
                        best_tot_reg <= '0;
                        best_mrk_reg <= '0;
                    end
                end
                S_RSCAN:
                begin
                    if (rd_vld_reg && key_rd_reg == key_reg)
                    begin
                        hit_reg <= 1'b1;
                        hit_idx_reg <= rd_idx_reg;
                        hit_tot_reg <= tot_rd_reg;
                        hit_mrk_reg <= mrk_rd_reg;
                        rd_vld_reg <= 1'b0;
                    end
                    else
                    begin
                        rd_vld_reg <= (addr_reg < count_reg);
                        rd_idx_reg <= addr_reg[IDX_W-1:0];
                        if (addr_reg < count_reg)
                            addr_reg <= addr_reg + 1'b1;
                    end
                end
                S_RWB:
                begin
                    if (hit_reg)
                    begin
                        if (mark_reg) any_reg <= 1'b1;
                    end
                    else if (count_reg < CNT_W'(ENTRIES))
                    begin
                        count_reg <= count_reg + 1'b1;
                        if (mark_reg) any_reg <= 1'b1;
                    end
                    else if (drop_reg != CNT_MAX)
                        drop_reg <= drop_reg + 16'd1;
                end
                S_PSCAN:
                begin
                    rd_vld_reg <= (addr_reg < count_reg);
                    rd_idx_reg <= addr_reg[IDX_W-1:0];
                    if (addr_reg < count_reg)
                        addr_reg <= addr_reg + 1'b1;
                    if (rd_vld_reg && !done_reg[rd_idx_reg] && better)
                    begin
                        best_vld_reg <= 1'b1;
                        best_idx_reg <= rd_idx_reg;
                        best_val_reg <= sk_val;
                        best_key_reg <= key_rd_reg;
                        best_tot_reg <= tot_rd_reg;
                        best_mrk_reg <= mrk_rd_reg;
                    end
                end
                S_PEMIT:
                begin
                    if (!out_vld_reg)
                    begin
                        done_reg[best_idx_reg] <= 1'b1;
                        emitted_reg <= emitted_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (!out_vld_reg)
                    begin
                        out_vld_reg <= 1'b1;
                        addr_reg <= '0;
                        rd_vld_reg <= 1'b0;
                        best_vld_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // load the beat in S_OUT once the register is free
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && !out_vld_reg)
        begin
            out_reg.site_key_res  <= best_key_reg;
            out_reg.total_count   <= best_tot_reg;
            out_reg.mark_count    <= best_mrk_reg;
            out_reg.empty_res     <= (count_reg == '0);
            out_reg.dropped_count <= (count_reg == '0) ? 16'd0 : drop_reg;
            out_reg.last          <= (emitted_reg >= count_reg);
        end
    end

    assign res.valid         = out_vld_reg;
    assign res.site_key_res  = out_reg.site_key_res;
    assign res.total_count   = out_reg.total_count;
    assign res.mark_count    = out_reg.mark_count;
    assign res.empty_res     = out_reg.empty_res;
    assign res.dropped_count = out_reg.dropped_count;
    assign res.last          = out_reg.last;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !cmd.ready)
        else $error("command taken while busy");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count beyond table size");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + 1'b1 || count_reg == '0))
        else $error("entry count jumped");
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        emitted_reg <= count_reg)
        else $error("more beats than entries");
endmodule
`default_nettype wire
